// File: src/stp_pkg.sv
package stp_pkg;

  localparam int SLOT_COUNT = 4;
  localparam int SLOT_IW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int STAGE_W    = $clog2(SLOT_COUNT + 1);

  localparam int DUTY_W  = 16;
  localparam int STAGE_T_W = 24;
  localparam int CFG_IW  = 3;
  localparam int CFG_DW  = 24;

  localparam int IN_DW   = 32;
  localparam int OUT_DW  = 40;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_KEY   = 2'd1,
    ACT_OTHER = 2'd2,
    ACT_SPARE = 2'd3
  } action_t;

  typedef enum logic [CFG_IW-1:0] {
    REG_MIN_DUTY    = 3'd0,
    REG_MAX_DUTY    = 3'd1,
    REG_DUTY_STEP   = 3'd2,
    REG_PWM_PERIOD  = 3'd3,
    REG_STAGE_TICKS = 3'd4
  } cfg_reg_t;

  localparam logic [15:0] SYM_UP    = 16'hF603;
  localparam logic [15:0] SYM_DOWN  = 16'hF600;
  localparam logic [15:0] SYM_RIGHT = 16'hF602;
  localparam logic [15:0] SYM_LEFT  = 16'hF601;
  localparam logic [15:0] SYM_SLOT0 = 16'hF031;
  localparam logic [15:0] SYM_ESC   = 16'hF01B;
  localparam logic [15:0] SYM_ENTER = 16'hF201;

  localparam logic [DUTY_W-1:0]    RST_MIN_DUTY    = 16'd200;
  localparam logic [DUTY_W-1:0]    RST_MAX_DUTY    = 16'd900;
  localparam logic [DUTY_W-1:0]    RST_DUTY_STEP   = 16'd50;
  localparam logic [DUTY_W-1:0]    RST_PWM_PERIOD  = 16'd20000;
  localparam logic [STAGE_T_W-1:0] RST_STAGE_TICKS = 24'd3000000;

endpackage

// File: src/servo_teach_and_playback.sv
// servo teach-and-playback controller
// the result word for an accepted input word is registered and shown in the next cycle
// throughput: one word per cycle while the result is drained, set by the single register stage on the result side
// the input is taken while the result register is empty or being drained
// reset (rst_n low, synchronous): registers to defaults, duties to the default min,
// slots undefined, playback off, counters zero; slot duty storage is not cleared
module servo_teach_and_playback import stp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IW-1:0]    cfg_index,
  input  logic [CFG_DW-1:0]    cfg_wdata,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // key_symbol[15:0], pressed[16], shift_state[24:17], zero fill
  input  logic [IN_DW-1:0]     in_tdata,
  // action[1:0]
  input  logic [1:0]           in_tuser,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // wrist_pulse[0], elbow_pulse[1], wrist_level[17:2], elbow_level[33:18],
  // playing[34], current_stage[37:35], start_refused[38], zero fill
  output logic [OUT_DW-1:0]    out_tdata
);

  logic [DUTY_W-1:0]    min_duty_r, max_duty_r, duty_step_r, pwm_period_r;
  logic [STAGE_T_W-1:0] stage_ticks_r;

  logic [DUTY_W-1:0]    wrist_r, elbow_r, wrist_nxt, elbow_nxt;
  logic [DUTY_W-1:0]    slot_wrist_r [SLOT_COUNT];
  logic [DUTY_W-1:0]    slot_elbow_r [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] defined_r, defined_nxt;
  logic [STAGE_W-1:0]   used_r, used_nxt, stage_r, stage_nxt;
  logic                 active_r, active_nxt;
  logic [DUTY_W-1:0]    period_r, period_nxt;
  logic [STAGE_T_W-1:0] count_r, count_nxt;

  logic                 out_valid_r;
  logic [OUT_DW-1:0]    out_data_r, out_data_nxt;

  logic                 accept;
  action_t              action;
  logic [15:0]          key;
  logic                 key_hit;
  logic                 slot_hit, slot_we;
  logic [SLOT_IW-1:0]   slot_k;
  logic [16:0]          slot_rel;
  logic                 wp, ep, refused;
  logic [DUTY_W:0]      pc_inc;
  logic [STAGE_T_W:0]   sc_inc;
  logic [STAGE_T_W-1:0] lim;
  logic [STAGE_W-1:0]   stage_eff;
  logic                 slots_ok;

  function automatic logic [DUTY_W-1:0] nudge_up(input logic [DUTY_W-1:0] d,
                                                 input logic [DUTY_W-1:0] st,
                                                 input logic [DUTY_W-1:0] mx);
    logic [DUTY_W:0] s;
    s = {1'b0, d} + {1'b0, st};
    return (s > {1'b0, mx}) ? mx : s[DUTY_W-1:0];
  endfunction

  function automatic logic [DUTY_W-1:0] nudge_down(input logic [DUTY_W-1:0] d,
                                                   input logic [DUTY_W-1:0] st,
                                                   input logic [DUTY_W-1:0] mn);
    logic [DUTY_W:0] s;
    s = {1'b0, mn} + {1'b0, st};
    return ({1'b0, d} < s) ? mn : d - st;
  endfunction

  assign accept    = in_tvalid && in_tready;
  assign in_tready = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign action   = action_t'(in_tuser);
  assign key      = in_tdata[15:0];
  assign key_hit  = (action == ACT_KEY) && in_tdata[16] && (in_tdata[24:17] == 8'd0);
  assign slot_rel = {1'b0, key} - {1'b0, SYM_SLOT0};
  assign slot_hit = !slot_rel[16] && (slot_rel[15:0] < 16'(SLOT_COUNT));
  assign slot_k   = slot_rel[SLOT_IW-1:0];

  always_comb begin
    slots_ok = (used_r != '0);
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if ((STAGE_W'(i) < used_r) && !defined_r[i]) slots_ok = 1'b0;
    end
  end

  assign pc_inc    = {1'b0, period_r} + 17'd1;
  assign sc_inc    = {1'b0, count_r} + 25'd1;
  assign lim       = (stage_ticks_r == '0) ? STAGE_T_W'(1) : stage_ticks_r;
  assign stage_eff = ((stage_r >= used_r) || (stage_r >= STAGE_W'(SLOT_COUNT))) ?
                     '0 : stage_r;

  always_comb begin
    wrist_nxt   = wrist_r;
    elbow_nxt   = elbow_r;
    defined_nxt = defined_r;
    used_nxt    = used_r;
    stage_nxt   = stage_r;
    active_nxt  = active_r;
    period_nxt  = period_r;
    count_nxt   = count_r;
    slot_we     = 1'b0;
    wp          = 1'b0;
    ep          = 1'b0;
    refused     = 1'b0;
    if (action == ACT_TICK) begin
      wp = (period_r < wrist_r);
      ep = (period_r < elbow_r);
      period_nxt = (pc_inc >= {1'b0, pwm_period_r}) ? '0 : pc_inc[DUTY_W-1:0];
      if (active_r) begin
        if (sc_inc >= {1'b0, lim}) begin
          count_nxt = '0;
          wrist_nxt = slot_wrist_r[stage_eff[SLOT_IW-1:0]];
          elbow_nxt = slot_elbow_r[stage_eff[SLOT_IW-1:0]];
          stage_nxt = stage_eff + STAGE_W'(1);
        end else begin
          count_nxt = sc_inc[STAGE_T_W-1:0];
        end
      end
    end else if (key_hit) begin
      if (key == SYM_UP) begin
        wrist_nxt = nudge_up(wrist_r, duty_step_r, max_duty_r);
      end else if (key == SYM_DOWN) begin
        wrist_nxt = nudge_down(wrist_r, duty_step_r, min_duty_r);
      end else if (key == SYM_LEFT) begin
        elbow_nxt = nudge_down(elbow_r, duty_step_r, min_duty_r);
      end else if (key == SYM_RIGHT) begin
        elbow_nxt = nudge_up(elbow_r, duty_step_r, max_duty_r);
      end else if (slot_hit) begin
        slot_we = 1'b1;
        if ({1'b0, used_r} < ({1'b0, STAGE_W'(slot_k)} + (STAGE_W+1)'(1))) begin
          used_nxt = STAGE_W'(slot_k) + STAGE_W'(1);
        end
        defined_nxt[slot_k] = 1'b1;
      end else if (key == SYM_ENTER) begin
        if (slots_ok) begin
          active_nxt = 1'b1;
          stage_nxt  = '0;
          count_nxt  = '0;
        end else begin
          active_nxt = 1'b0;
          refused    = 1'b1;
        end
      end else if (key == SYM_ESC) begin
        active_nxt  = 1'b0;
        used_nxt    = '0;
        defined_nxt = '0;
        count_nxt   = '0;
      end
    end
    out_data_nxt = '0;
    out_data_nxt[0]     = wp;
    out_data_nxt[1]     = ep;
    out_data_nxt[17:2]  = wrist_nxt;
    out_data_nxt[33:18] = elbow_nxt;
    out_data_nxt[34]    = active_nxt;
    out_data_nxt[37:35] = 3'(stage_nxt);
    out_data_nxt[38]    = refused;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_duty_r    <= RST_MIN_DUTY;
      max_duty_r    <= RST_MAX_DUTY;
      duty_step_r   <= RST_DUTY_STEP;
      pwm_period_r  <= RST_PWM_PERIOD;
      stage_ticks_r <= RST_STAGE_TICKS;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_MIN_DUTY:    min_duty_r    <= cfg_wdata[DUTY_W-1:0];
        REG_MAX_DUTY:    max_duty_r    <= cfg_wdata[DUTY_W-1:0];
        REG_DUTY_STEP:   duty_step_r   <= cfg_wdata[DUTY_W-1:0];
        REG_PWM_PERIOD:  pwm_period_r  <= cfg_wdata[DUTY_W-1:0];
        REG_STAGE_TICKS: stage_ticks_r <= cfg_wdata[STAGE_T_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrist_r     <= RST_MIN_DUTY;
      elbow_r     <= RST_MIN_DUTY;
      defined_r   <= '0;
      used_r      <= '0;
      stage_r     <= '0;
      active_r    <= 1'b0;
      period_r    <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        wrist_r   <= wrist_nxt;
        elbow_r   <= elbow_nxt;
        defined_r <= defined_nxt;
        used_r    <= used_nxt;
        stage_r   <= stage_nxt;
        active_r  <= active_nxt;
        period_r  <= period_nxt;
        count_r   <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // slot storage and result word, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
      if (slot_we) begin
        slot_wrist_r[slot_k] <= wrist_r;
        slot_elbow_r[slot_k] <= elbow_r;
      end
    end
  end

endmodule
